// File: rtl/core/rgbfade_pkg.sv
// shared types and constants of the rgb colour fade sequencer
`default_nettype none

package rgbfade_pkg;

  // fixed field widths
  localparam int unsigned NumChan  = 3;
  localparam int unsigned ChanW    = 2;
  localparam int unsigned ColorW   = 8;
  localparam int unsigned StepsW   = 10;
  localparam int unsigned PosW     = 11;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 10;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgStartRed   = 3'd0,
    CfgStartGreen = 3'd1,
    CfgStartBlue  = 3'd2,
    CfgEndRed     = 3'd3,
    CfgEndGreen   = 3'd4,
    CfgEndBlue    = 3'd5,
    CfgFadeSteps  = 3'd6,
    CfgRepeatMode = 3'd7
  } cfg_idx_e;

  // behaviour once the fade has run out; the unused code acts as hold
  typedef enum logic [ModeW-1:0] {
    RepHold     = 2'd0,
    RepLoop     = 2'd1,
    RepPingPong = 2'd2
  } repeat_e;

  // what the level unit does to one channel
  typedef enum logic [1:0] {
    OpStart = 2'd0,
    OpEnd   = 2'd1,
    OpSub   = 2'd2,
    OpAdd   = 2'd3
  } level_op_e;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/rgbfade_div.sv
// iterative restoring divider, one quotient bit per cycle
`default_nettype none

module rgbfade_div import rgbfade_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 24,
  parameter int unsigned DIVISOR_W  = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic      [DIVIDEND_W-1:0] quotient_o,
  output div_stat_t                  stat_o
);

  localparam int unsigned CntW = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  den_q;
  logic [CntW-1:0]       cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;
  logic [DIVISOR_W-1:0]  rem_d;
  logic [DIVIDEND_W-1:0] quo_d;

  // one trial subtraction a cycle
  always_comb begin
    trial = {rem_q, quo_q[DIVIDEND_W-1]};
    diff  = {1'b0, trial} - {2'b00, den_q};
    fits  = ~diff[DIVISOR_W+1];
    rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    quo_d = {quo_q[DIVIDEND_W-2:0], fits};
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(DIVIDEND_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

`default_nettype wire

// File: rtl/core/rgbfade_alu.sv
// shared level unit: load a colour, or add or subtract a step with saturation
`default_nettype none

module rgbfade_alu import rgbfade_pkg::*; #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  level_op_e                              op_i,
  input  wire logic signed [FRACTION_BITS+9:0]   level_i,
  input  wire logic signed [FRACTION_BITS+8:0]   step_i,
  input  wire logic        [ColorW-1:0]          start_i,
  input  wire logic        [ColorW-1:0]          end_i,
  output logic signed      [FRACTION_BITS+9:0]   level_o
);

  localparam int unsigned LevelW = FRACTION_BITS + 10;

  logic signed [LevelW:0]   level_x;
  logic signed [LevelW:0]   step_x;
  logic signed [LevelW:0]   sum;
  logic signed [LevelW-1:0] sat;

  // widen the level by one bit and the step by two so the sum cannot wrap
  always_comb begin
    level_x = {level_i[LevelW-1], level_i};
    step_x  = {{2{step_i[LevelW-2]}}, step_i};
    if (op_i == OpAdd) begin
      sum = level_x + step_x;
    end else begin
      sum = level_x - step_x;
    end
    if (sum[LevelW] != sum[LevelW-1]) begin
      sat = sum[LevelW] ? {1'b1, {(LevelW-1){1'b0}}} : {1'b0, {(LevelW-1){1'b1}}};
    end else begin
      sat = sum[LevelW-1:0];
    end
  end

  // select the new level
  always_comb begin
    unique case (op_i)
      OpStart: level_o = {2'b00, start_i, {FRACTION_BITS{1'b0}}};
      OpEnd:   level_o = {2'b00, end_i, {FRACTION_BITS{1'b0}}};
      OpSub:   level_o = sat;
      OpAdd:   level_o = sat;
      default: level_o = sat;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/rgb_color_fade_sequencer.sv
// top level: linear rgb colour fade, one colour word per frame tick
//
// Channels: the slave stream takes one frame tick per word (tdata bit 0 is
// restart), the master stream gives one colour word per tick, and a separate
// write channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) sets the
// start and end colours, the fade length and the repeat mode. Configuration
// is always ready; the user must write it only while no tick is in flight, as the block itself does not enforce this.
// Sequence: a tick without restart runs the three channels through the shared
// level unit, one per cycle, then loads the output register; the colour
// word shows in the same cycle that the block is ready again.
// A restart tick first runs the shared divider once per channel, each run
// giving that channel's step, before the level updates.
// One tick is processed at a time; s_axis_tready_o is high only when idle.
// Reset: colours to white, fade length 1, hold mode, position 1, zero
// deltas and levels, no word pending.
// Stall: the output register keeps its word until taken; a new tick is
// accepted meanwhile, and its result waits in the sequencer until the
// register is free.
`default_nettype none

module rgb_color_fade_sequencer import rgbfade_pkg::*; #(
  parameter int unsigned MAX_FADE_STEPS = 1023,
  parameter int unsigned FRACTION_BITS  = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // frame tick stream
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [7:0]          s_axis_tdata_i,   // [0] restart, [7:1] zero
  // colour stream
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic      [23:0]         m_axis_tdata_o,   // [7:0] red, [15:8] green, [23:16] blue
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned LevelW      = FRACTION_BITS + 10;
  localparam int unsigned StepW       = FRACTION_BITS + 9;
  localparam int unsigned QuoW        = FRACTION_BITS + 8;
  localparam int unsigned MaxStepsCap = (MAX_FADE_STEPS > 1023) ? 1023 : MAX_FADE_STEPS;
  localparam logic [StepsW-1:0] MaxSteps = StepsW'(MaxStepsCap);
  localparam logic [ChanW-1:0]  LastChan = ChanW'(NumChan - 1);

  typedef enum logic [2:0] {
    StIdle,
    StDivLoad,
    StDivRun,
    StUpdate,
    StEmit
  } state_e;

  // configuration registers
  logic [ColorW-1:0] start_q [NumChan];
  logic [ColorW-1:0] end_q   [NumChan];
  logic [StepsW-1:0] steps_q;
  logic [ModeW-1:0]  mode_q;

  // sequencer state
  state_e                   state_q;
  logic [ChanW-1:0]         chan_q;
  level_op_e                op_q;
  logic [PosW-1:0]          pos_q;
  logic signed [StepW-1:0]  step_q  [NumChan];
  logic signed [LevelW-1:0] level_q [NumChan];
  logic                     out_valid_q;
  logic [23:0]              out_data_q;

  logic                     in_acc;
  logic                     restart;
  logic [StepsW-1:0]        steps_eff;
  logic [PosW-1:0]          steps_ext;
  logic [PosW-1:0]          top_pos;
  logic [PosW-1:0]          pos_eff;
  logic [PosW-1:0]          pos_d;
  level_op_e                op_d;

  logic [ColorW-1:0]        ch_start;
  logic [ColorW-1:0]        ch_end;
  logic                     ch_neg;
  logic [ColorW-1:0]        ch_mag;
  logic [QuoW-1:0]          div_dividend;
  logic [StepsW-1:0]        div_divisor;
  logic [QuoW-1:0]          div_quotient;
  div_stat_t                div_stat;
  logic                     div_start;
  logic [StepW-1:0]         quo_ext;
  logic signed [StepW-1:0]  step_d;
  logic signed [LevelW-1:0] alu_level;
  logic [23:0]              colour;

  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign restart         = s_axis_tdata_i[0];
  assign s_axis_tready_o = (state_q == StIdle);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NumChan; c++) begin
        start_q[c] <= '1;
        end_q[c]   <= '1;
      end
      steps_q <= StepsW'(1);
      mode_q  <= RepHold;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgStartRed:   start_q[0] <= cfg_data_i[ColorW-1:0];
        CfgStartGreen: start_q[1] <= cfg_data_i[ColorW-1:0];
        CfgStartBlue:  start_q[2] <= cfg_data_i[ColorW-1:0];
        CfgEndRed:     end_q[0]   <= cfg_data_i[ColorW-1:0];
        CfgEndGreen:   end_q[1]   <= cfg_data_i[ColorW-1:0];
        CfgEndBlue:    end_q[2]   <= cfg_data_i[ColorW-1:0];
        CfgFadeSteps:  steps_q    <= cfg_data_i[StepsW-1:0];
        CfgRepeatMode: mode_q     <= cfg_data_i[ModeW-1:0];
        default:       mode_q     <= mode_q;
      endcase
    end
  end

  // effective fade length and ping-pong turning point
  always_comb begin
    priority if (steps_q == '0) begin
      steps_eff = StepsW'(1);
    end else if (steps_q > MaxSteps) begin
      steps_eff = MaxSteps;
    end else begin
      steps_eff = steps_q;
    end
    steps_ext = {1'b0, steps_eff};
    top_pos   = {steps_eff, 1'b0} - PosW'(2);
  end

  // level action and next position of this tick
  always_comb begin
    pos_eff = restart ? PosW'(1) : pos_q;
    priority if (pos_eff <= steps_ext) begin
      pos_d = pos_eff + PosW'(1);
      priority if (pos_eff == PosW'(1)) begin
        op_d = OpStart;
      end else if (pos_eff == steps_ext) begin
        op_d = OpEnd;
      end else begin
        op_d = OpSub;
      end
    end else if (mode_q == RepLoop) begin
      op_d  = OpStart;
      pos_d = PosW'(2);
    end else if (mode_q == RepPingPong) begin
      op_d  = OpAdd;
      pos_d = (pos_eff < top_pos) ? pos_eff + PosW'(1) : PosW'(1);
    end else begin
      op_d  = OpEnd;
      pos_d = pos_eff;
    end
  end

  // divider operands of the current channel: |start-end| scaled, over steps-1
  always_comb begin
    ch_start     = start_q[chan_q];
    ch_end       = end_q[chan_q];
    ch_neg       = ch_start < ch_end;
    ch_mag       = ch_neg ? ch_end - ch_start : ch_start - ch_end;
    div_dividend = {ch_mag, {FRACTION_BITS{1'b0}}};
    div_divisor  = steps_eff - StepsW'(1);
    div_start    = (state_q == StDivLoad);
    quo_ext      = {1'b0, div_quotient};
    if (steps_eff <= StepsW'(1)) begin
      step_d = '0;
    end else if (ch_neg) begin
      step_d = -$signed(quo_ext);
    end else begin
      step_d = $signed(quo_ext);
    end
  end

  rgbfade_div #(
    .DIVIDEND_W (QuoW),
    .DIVISOR_W  (StepsW)
  ) u_rgbfade_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quotient),
    .stat_o     (div_stat)
  );

  rgbfade_alu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_rgbfade_alu (
    .op_i    (op_q),
    .level_i (level_q[chan_q]),
    .step_i  (step_q[chan_q]),
    .start_i (ch_start),
    .end_i   (ch_end),
    .level_o (alu_level)
  );

  // integer part of each level, saturated to a byte
  always_comb begin
    for (int c = 0; c < NumChan; c++) begin
      if (level_q[c][LevelW-1]) begin
        colour[c*ColorW +: ColorW] = '0;
      end else if (level_q[c][LevelW-2]) begin
        colour[c*ColorW +: ColorW] = '1;
      end else begin
        colour[c*ColorW +: ColorW] = level_q[c][FRACTION_BITS +: ColorW];
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      chan_q      <= '0;
      op_q        <= OpStart;
      pos_q       <= PosW'(1);
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      for (int c = 0; c < NumChan; c++) begin
        step_q[c]  <= '0;
        level_q[c] <= '0;
      end
    end else begin
      if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            pos_q   <= pos_d;
            op_q    <= op_d;
            chan_q  <= '0;
            state_q <= restart ? StDivLoad : StUpdate;
          end
        end
        StDivLoad: begin
          state_q <= StDivRun;
        end
        StDivRun: begin
          if (div_stat.done) begin
            step_q[chan_q] <= step_d;
            if (chan_q == LastChan) begin
              chan_q  <= '0;
              state_q <= StUpdate;
            end else begin
              chan_q  <= chan_q + ChanW'(1);
              state_q <= StDivLoad;
            end
          end
        end
        StUpdate: begin
          level_q[chan_q] <= alu_level;
          if (chan_q == LastChan) begin
            chan_q  <= '0;
            state_q <= StEmit;
          end else begin
            chan_q <= chan_q + ChanW'(1);
          end
        end
        StEmit: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_data_q  <= colour;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rgbfade_checker.sv
// port-level checks of the colour fade sequencer, bound to the top level
`default_nettype none

module rgbfade_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);

  logic tick_acc;

  assign tick_acc = s_axis_tvalid_i & s_axis_tready_o;

  // a stalled colour word keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("colour word changed while stalled");

  // one tick at a time: busy right after acceptance
  a_busy_after_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> !s_axis_tready_o)
    else $error("tick stream ready right after a tick");

  // the colour word never appears the cycle after its tick
  a_no_instant_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> !$rose(m_axis_tvalid_o))
    else $error("colour word raised too early");

  // a new colour word only comes out of a busy period
  a_word_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("colour word raised while idle");

endmodule

bind rgb_color_fade_sequencer rgbfade_checker u_rgbfade_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

`default_nettype wire
